[rtl/lfu_pkg.sv]
`timescale 1ns / 1ps
package lfu_pkg;
  localparam int Entries   = 16;
  localparam int IdxBits   = $clog2(Entries);
  localparam int FillBits  = $clog2(Entries + 1);
  localparam int CountBits = 16;
  localparam int CapBits   = 5;
  localparam int KeyBits   = 32;
  localparam int ValBits   = 32;
  // Victim chain segment length: at most three segments, two registered cuts.
  localparam int ChainSeg  = (Entries + 2) / 3;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};
  localparam logic [CapBits-1:0] CapReset = CapBits'(16);

  typedef enum logic [0:0] {OpGet = 1'b0, OpPut = 1'b1} op_e;

  typedef enum logic [1:0] {
    StIdle, StSearch, StUpdate, StOut
  } state_e;

  // Per-cell view handed to the victim chain and controller.
  typedef struct packed {
    logic                 valid;
    logic                 match;
    logic [KeyBits-1:0]   key;
    logic [ValBits-1:0]   value;
    logic [CountBits-1:0] count;
    logic [IdxBits-1:0]   rank;
  } cell_status_t;

  // Command broadcast from controller to all cells.
  typedef struct packed {
    logic                 update;    // apply the operation this cycle
    logic                 hit;       // key was found
    logic                 put;
    logic                 fill;      // install into target cell
    logic [IdxBits-1:0]   target;    // cell index that becomes most recent
    logic [IdxBits:0]     old_rank;  // rank threshold for aging
    logic [KeyBits-1:0]   key;
    logic [ValBits-1:0]   value;
  } cell_cmd_t;

  // Running best of the victim chain.
  typedef struct packed {
    logic                 found;
    logic [IdxBits-1:0]   idx;
    logic [CountBits-1:0] count;
    logic [IdxBits-1:0]   rank;
  } victim_t;
endpackage

[rtl/lfu_cell.sv]
`timescale 1ns / 1ps
module lfu_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [lfu_pkg::IdxBits-1:0] my_idx_i,
  input  lfu_pkg::cell_cmd_t cmd_i,
  input  logic [lfu_pkg::KeyBits-1:0] lookup_key_i,
  input  lfu_pkg::victim_t   best_i,
  output lfu_pkg::victim_t   best_o,
  output lfu_pkg::cell_status_t status_o
);
  import lfu_pkg::*;

  logic                 valid_q;
  logic [KeyBits-1:0]   key_q;
  logic [ValBits-1:0]   value_q;
  logic [CountBits-1:0] count_q;
  logic [IdxBits-1:0]   rank_q;
  logic                 is_target;
  logic                 better;

  assign is_target = cmd_i.update && (cmd_i.target == my_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (is_target && (cmd_i.hit || cmd_i.put)) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      if (is_target) begin
        rank_q <= '0;
        if (cmd_i.hit) begin
          if (count_q != CountMax) count_q <= count_q + 1'b1;
          if (cmd_i.put) value_q <= cmd_i.value;
        end else if (cmd_i.put) begin
          key_q   <= cmd_i.key;
          value_q <= cmd_i.value;
          count_q <= CountBits'(1);
        end
      end else if (valid_q && ({1'b0, rank_q} < cmd_i.old_rank)) begin
        rank_q <= rank_q + 1'b1;
      end
    end
  end

  // Smallest count wins, older rank among equal counts.
  assign better = valid_q && (!best_i.found || count_q < best_i.count ||
                  (count_q == best_i.count && rank_q > best_i.rank));

  always_comb begin
    best_o = best_i;
    if (better) begin
      best_o.found = 1'b1;
      best_o.idx   = my_idx_i;
      best_o.count = count_q;
      best_o.rank  = rank_q;
    end
  end

  always_comb begin
    status_o.valid = valid_q;
    status_o.match = valid_q && (key_q == lookup_key_i);
    status_o.key   = key_q;
    status_o.value = value_q;
    status_o.count = count_q;
    status_o.rank  = rank_q;
  end
endmodule

[rtl/lfu_cache_lru_tiebreak_top.sv]
`timescale 1ns / 1ps
// LFU cache with LRU tie break, sixteen entries, 32-bit keys and values.
// Input channel: in_valid_i / in_stall_o with opcode_i (0 get, 1 put),
// key_i and write_value_i. Output channel: out_valid_o / out_stall_i with
// hit_o, read_value_o, evicted_o, evicted_key_o; exactly one result per
// input transfer. Configuration: cfg_we_i with cfg_wdata_i writes the
// capacity register (values above sixteen act as sixteen, zero ignores puts).
// Each operation passes through capture, key compare and victim pick,
// entry update, and result register. The next input is taken only after
// the result leaves, so one operation is in flight at a time.
// The victim search runs continuously down the row of entry cells, with a
// register after every sixth cell; after an entry update it settles through
// both cuts before the next operation reaches its search step.
// Reset empties the store and sets capacity to sixteen. While the receiver
// stalls, hold the result and take no new input.
module lfu_cache_lru_tiebreak_top (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic opcode_i,
  input  logic [lfu_pkg::KeyBits-1:0] key_i,
  input  logic [lfu_pkg::ValBits-1:0] write_value_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic hit_o,
  output logic [lfu_pkg::ValBits-1:0] read_value_o,
  output logic evicted_o,
  output logic [lfu_pkg::KeyBits-1:0] evicted_key_o,
  input  logic cfg_we_i,
  input  logic [lfu_pkg::CapBits-1:0] cfg_wdata_i
);
  import lfu_pkg::*;

  state_e state_q, state_d;
  logic [CapBits-1:0]  cap_q;
  logic [FillBits-1:0] fill_q;
  logic                op_q;
  logic [KeyBits-1:0]  key_q;
  logic [ValBits-1:0]  wval_q;

  // Registered search results.
  logic               hit_q, free_q, ev_q, ignore_q;
  logic [IdxBits-1:0] tgt_q;
  logic [IdxBits:0]   oldrank_q;
  logic [ValBits-1:0] rd_q;
  logic [KeyBits-1:0] evk_q;

  logic               out_hit_q, out_ev_q;
  logic [ValBits-1:0] out_rd_q;
  logic [KeyBits-1:0] out_evk_q;

  cell_cmd_t    cmd;
  cell_status_t status [Entries];
  victim_t      chain [Entries+1];
  victim_t      link  [Entries];

  assign chain[0] = '0;

  // Cut the victim chain with a register every ChainSeg cells.
  for (genvar g = 0; g < Entries; g++) begin : g_cell
    if (g != 0 && (g % ChainSeg) == 0) begin : g_cut
      victim_t cut_q;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          cut_q <= '0;
        end else begin
          cut_q <= chain[g];
        end
      end
      assign link[g] = cut_q;
    end else begin : g_thru
      assign link[g] = chain[g];
    end

    lfu_cell u_cell (
      .clk_i, .rst_ni,
      .my_idx_i    (IdxBits'(g)),
      .cmd_i       (cmd),
      .lookup_key_i(key_q),
      .best_i      (link[g]),
      .best_o      (chain[g+1]),
      .status_o    (status[g])
    );
  end

  // Match, free slot and effective capacity.
  logic               s_hit, s_free;
  logic [IdxBits-1:0] s_hidx, s_fidx;
  logic [FillBits-1:0] cap_eff;

  always_comb begin
    s_hit = 1'b0; s_hidx = '0; s_free = 1'b0; s_fidx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (status[i].match) begin
        s_hit = 1'b1; s_hidx = IdxBits'(i);
      end
      if (!status[i].valid) begin
        s_free = 1'b1; s_fidx = IdxBits'(i);
      end
    end
    cap_eff = (cap_q > CapBits'(Entries)) ? FillBits'(Entries) : FillBits'(cap_q);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (in_valid_i) state_d = StSearch;
      StSearch: state_d = StUpdate;
      StUpdate: state_d = StOut;
      StOut:    if (!out_stall_i) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cap_q   <= CapReset;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (state_q == StUpdate && !ignore_q && !hit_q && free_q) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // Capture input and search outcome.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      op_q   <= opcode_i;
      key_q  <= key_i;
      wval_q <= write_value_i;
    end
    if (state_q == StSearch) begin
      hit_q    <= s_hit;
      ignore_q <= (op_q == OpGet) ? !s_hit : (cap_eff == '0);
      rd_q     <= (s_hit && op_q == OpGet) ? status[s_hidx].value : '0;
      free_q   <= 1'b0;
      ev_q     <= 1'b0;
      evk_q    <= '0;
      if (s_hit) begin
        tgt_q     <= s_hidx;
        oldrank_q <= {1'b0, status[s_hidx].rank};
      end else if (fill_q < cap_eff && s_free) begin
        free_q    <= 1'b1;
        tgt_q     <= s_fidx;
        oldrank_q <= (IdxBits+1)'(Entries);
      end else begin
        ev_q      <= (op_q == OpPut) && (cap_eff != '0);
        tgt_q     <= chain[Entries].idx;
        oldrank_q <= {1'b0, chain[Entries].rank};
        evk_q     <= status[chain[Entries].idx].key;
      end
    end
    if (state_q == StUpdate) begin
      out_hit_q <= hit_q && !ignore_q;
      out_rd_q  <= rd_q;
      out_ev_q  <= ev_q && !ignore_q;
      out_evk_q <= (ev_q && !ignore_q) ? evk_q : '0;
    end
  end

  always_comb begin
    cmd.update   = (state_q == StUpdate) && !ignore_q;
    cmd.hit      = hit_q;
    cmd.put      = (op_q == OpPut);
    cmd.fill     = free_q;
    cmd.target   = tgt_q;
    cmd.old_rank = oldrank_q;
    cmd.key      = key_q;
    cmd.value    = wval_q;
  end

  assign in_stall_o    = (state_q != StIdle);
  assign out_valid_o   = (state_q == StOut);
  assign hit_o         = out_hit_q;
  assign read_value_o  = out_rd_q;
  assign evicted_o     = out_ev_q;
  assign evicted_key_o = out_evk_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillBits'(Entries)) else $error("fill count overflow");
  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StUpdate |=> out_valid_o) else $error("result missing");
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while busy");
endmodule
